### rtl/lfp_pkg.sv
// Shared types, constants and the X.25 CRC step for the link frame parser.
package lfp_pkg;

   localparam logic [7:0]  MARKER_DEFAULT = 8'hFE;
   localparam logic [15:0] CRC_SEED       = 16'hFFFF;

   localparam logic [1:0] STATUS_IDLE    = 2'd0;
   localparam logic [1:0] STATUS_PARSING = 2'd1;
   localparam logic [1:0] STATUS_GOOD    = 2'd2;
   localparam logic [1:0] STATUS_ERROR   = 2'd3;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] frame_payload_length;
   } result_type;

   function automatic logic [15:0] x25_update(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] t;
      t = b ^ crc[7:0];
      t = t ^ {t[3:0], 4'b0000};
      return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
   endfunction

endpackage

### rtl/lfp_if.sv
// Channel interfaces: received bytes, parse results and the marker register write.
interface lfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] frame_payload_length;
   modport source (output valid, output status, output frame_payload_length, input ready);
   modport sink (input valid, input status, input frame_payload_length, output ready);
endinterface

interface lfp_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### rtl/lfp_parser.sv
// Frame phase sequencer with running CRC, payload counter and checksum low byte.
module lfp_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         rx_byte,
   input  logic [7:0]         start_marker,
   output lfp_pkg::result_type result
);

   typedef enum logic [3:0] {
      PH_HUNT = 4'd0,
      PH_LEN  = 4'd1,
      PH_SEQ  = 4'd2,
      PH_SYS  = 4'd3,
      PH_COMP = 4'd4,
      PH_MSG  = 4'd5,
      PH_PAY  = 4'd6,
      PH_CKL  = 4'd7,
      PH_CKH  = 4'd8
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  cklow_ff, cklow_in;
   logic [15:0] crc_step;
   logic [7:0]  count_inc;
   logic [1:0]  status;

   assign crc_step  = lfp_pkg::x25_update(crc_ff, rx_byte);
   assign count_inc = count_ff + 8'd1;

   always_comb begin
      phase_in  = phase_ff;
      crc_in    = crc_ff;
      count_in  = count_ff;
      length_in = length_ff;
      cklow_in  = cklow_ff;
      status    = lfp_pkg::STATUS_PARSING;
      case (phase_ff)
         PH_LEN: begin
            crc_in    = crc_step;
            length_in = rx_byte;
            phase_in  = PH_SEQ;
         end
         PH_SEQ: begin
            crc_in   = crc_step;
            phase_in = PH_SYS;
         end
         PH_SYS: begin
            crc_in   = crc_step;
            phase_in = PH_COMP;
         end
         PH_COMP: begin
            crc_in   = crc_step;
            phase_in = PH_MSG;
         end
         PH_MSG: begin
            crc_in   = crc_step;
            count_in = 8'd0;
            phase_in = (length_ff == 8'd0) ? PH_CKL : PH_PAY;
         end
         PH_PAY: begin
            crc_in   = crc_step;
            count_in = count_inc;
            if (count_inc >= length_ff) begin
               phase_in = PH_CKL;
            end
         end
         PH_CKL: begin
            cklow_in = rx_byte;
            phase_in = PH_CKH;
         end
         PH_CKH: begin
            status   = ({rx_byte, cklow_ff} == crc_ff) ? lfp_pkg::STATUS_GOOD
                                                       : lfp_pkg::STATUS_ERROR;
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
            if (rx_byte == start_marker) begin
               crc_in    = lfp_pkg::CRC_SEED;
               length_in = 8'd0;
               phase_in  = PH_LEN;
            end else begin
               status = lfp_pkg::STATUS_IDLE;
            end
         end
      endcase
      result.status               = status;
      result.frame_payload_length = (status == lfp_pkg::STATUS_IDLE) ? 8'd0 : length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         crc_ff    <= lfp_pkg::CRC_SEED;
         count_ff  <= 8'd0;
         length_ff <= 8'd0;
         cklow_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         crc_ff    <= crc_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         cklow_ff  <= cklow_in;
      end
   end

endmodule

### rtl/lfp_rsp_reg.sv
// Result register that holds one parse result until the sink takes it.
module lfp_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  lfp_pkg::result_type result,
   output logic                busy,
   lfp_rsp_if.source           rsp_chan
);

   logic                valid_ff, valid_in;
   lfp_pkg::result_type data_ff;

   assign busy     = valid_ff && !rsp_chan.ready;
   assign valid_in = load || busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid                = valid_ff;
   assign rsp_chan.status               = data_ff.status;
   assign rsp_chan.frame_payload_length = data_ff.frame_payload_length;

endmodule

### rtl/link_frame_parser_crc16.sv
// Top level of the link frame parser with X.25 CRC-16 check.
// Each received byte is one transaction and yields exactly one result transaction:
// idle, parsing, checksum good or checksum error, with the current frame's payload
// length. The block takes one byte per clock unless stalled; the phase step and the
// bytewise CRC update are combinational; the result shows on the rsp channel the
// cycle after its byte is accepted. A single result register decouples the sides:
// req_chan.ready is low only while a result is held and rsp_chan.ready is low.
// Write start_marker (reset 0xFE) on the csr channel only while the parser is idle.
module link_frame_parser_crc16 (
   input  logic      clock,
   input  logic      reset,
   lfp_req_if.sink   req_chan,
   lfp_rsp_if.source rsp_chan,
   lfp_csr_if.sink   csr_chan
);

   logic                accept;
   logic                busy;
   logic [7:0]          marker_ff;
   lfp_pkg::result_type result;

   assign req_chan.ready = !busy;
   assign accept         = req_chan.valid && !busy;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= lfp_pkg::MARKER_DEFAULT;
      end else if (csr_chan.valid) begin
         marker_ff <= csr_chan.data;
      end
   end

   lfp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_chan.rx_byte),
      .start_marker (marker_ff),
      .result       (result)
   );

   lfp_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .result   (result),
      .busy     (busy),
      .rsp_chan (rsp_chan)
   );

endmodule

### rtl/lfp_checker.sv
// Port-level checks on the link frame parser, bound to the top level.
module lfp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_length
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted transaction gave no result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lfp_pkg::STATUS_IDLE |-> rsp_length == 8'd0)
      else $error("idle result with nonzero length");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_length))
      else $error("stalled result changed");

endmodule

bind link_frame_parser_crc16 lfp_checker u_lfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_length (rsp_chan.frame_payload_length)
);

### dv/lfp_parse_checker.sv
// Checker for the link frame parser: predicts each result and compares it to the rsp channel.
`timescale 1ns / 1ps
module lfp_parse_checker (
   input  logic  clock,
   input  logic  reset,
   lfp_req_if    req_mon,
   lfp_rsp_if    rsp_mon,
   lfp_csr_if    csr_mon,
   output int    fail_count,
   output int    pending,
   output logic  hunting
);

   typedef enum logic [3:0] {
      PH_HUNT, PH_LENGTH, PH_SEQ, PH_SYSID, PH_COMPID, PH_MSGID, PH_PAYLOAD, PH_CRC_LO, PH_CRC_HI
   } parse_phase_type;

   parse_phase_type     ph;
   logic [7:0]          marker;
   logic [15:0]         crc;
   logic [7:0]          pay_count;
   logic [7:0]          frame_len;
   logic [7:0]          crc_lo;
   lfp_pkg::result_type expected_results[$];

   function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
      end
      return c;
   endfunction

   function automatic lfp_pkg::result_type advance_parser(input logic [7:0] b);
      lfp_pkg::result_type r;
      r.status = lfp_pkg::STATUS_PARSING;
      if (ph >= PH_LENGTH && ph <= PH_PAYLOAD) begin
         crc = crc_step(crc, b);
      end
      case (ph)
         PH_LENGTH: begin
            frame_len = b;
            ph = PH_SEQ;
         end
         PH_SEQ:    ph = PH_SYSID;
         PH_SYSID:  ph = PH_COMPID;
         PH_COMPID: ph = PH_MSGID;
         PH_MSGID: begin
            pay_count = 8'h00;
            ph = (frame_len == 8'h00) ? PH_CRC_LO : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            pay_count = pay_count + 8'h01;
            if (pay_count >= frame_len) begin
               ph = PH_CRC_LO;
            end
         end
         PH_CRC_LO: begin
            crc_lo = b;
            ph = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            r.status = ({b, crc_lo} == crc) ? lfp_pkg::STATUS_GOOD : lfp_pkg::STATUS_ERROR;
            ph = PH_HUNT;
         end
         default: begin
            ph = PH_HUNT;
            if (b == marker) begin
               crc = lfp_pkg::CRC_SEED;
               frame_len = 8'h00;
               ph = PH_LENGTH;
            end else begin
               r.status = lfp_pkg::STATUS_IDLE;
            end
         end
      endcase
      r.frame_payload_length = (r.status == lfp_pkg::STATUS_IDLE) ? 8'h00 : frame_len;
      return r;
   endfunction

   initial fail_count = 0;

   always @(posedge clock) begin
      lfp_pkg::result_type want;
      if (reset) begin
         ph = PH_HUNT;
         marker = lfp_pkg::MARKER_DEFAULT;
         crc = lfp_pkg::CRC_SEED;
         pay_count = 8'h00;
         frame_len = 8'h00;
         crc_lo = 8'h00;
         expected_results.delete();
         pending <= 0;
         hunting <= 1'b1;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            marker = csr_mon.data;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result transaction: status %0d, length %0d",
                      rsp_mon.status, rsp_mon.frame_payload_length);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_mon.status);
                  fail_count++;
               end
               if (rsp_mon.frame_payload_length !== want.frame_payload_length) begin
                  $error("frame_payload_length mismatch: expected %0d, actual %0d",
                         want.frame_payload_length, rsp_mon.frame_payload_length);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_results.push_back(advance_parser(req_mon.rx_byte));
         end
         pending <= expected_results.size();
         hunting <= (ph == PH_HUNT);
      end
   end

endmodule

### dv/tb_top.sv
// Testbench top: drives byte streams and marker writes into the link frame parser.
`timescale 1ns / 1ps
module tb_top;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lfp_req_if req_chan();
   lfp_rsp_if rsp_chan();
   lfp_csr_if csr_chan();

   int         fail_count;
   int         pending;
   logic       hunting;
   int         req_gap_pct;
   int         rsp_stall_pct;
   int         bytes_sent;
   logic [7:0] cur_marker;

   always #2 clock = ~clock;

   link_frame_parser_crc16 u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   lfp_parse_checker u_parse_chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_mon    (csr_chan),
      .fail_count (fail_count),
      .pending    (pending),
      .hunting    (hunting)
   );

   function automatic logic [15:0] frame_crc(input logic [15:0] c_in, input logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
      end
      return c;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      if (req_gap_pct > 0 && $urandom_range(99, 0) < req_gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(14, 1)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (2) @(posedge clock);
   endtask

   // cut < 0 or cut >= frame size sends the whole frame; otherwise stop after cut bytes
   task automatic send_frame(input int len, input bit corrupt, input int cut);
      logic [7:0]  frame_bytes[$];
      logic [15:0] crc;
      int          n;
      frame_bytes.push_back(cur_marker);
      frame_bytes.push_back(len[7:0]);
      repeat (4) frame_bytes.push_back(8'($urandom_range(255, 0)));
      repeat (len) frame_bytes.push_back(8'($urandom_range(255, 0)));
      crc = lfp_pkg::CRC_SEED;
      for (int i = 1; i < frame_bytes.size(); i++) begin
         crc = frame_crc(crc, frame_bytes[i]);
      end
      if (corrupt) begin
         crc = crc ^ (16'h0001 << $urandom_range(15, 0));
      end
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
      n = (cut >= 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
      for (int i = 0; i < n; i++) begin
         send_byte(frame_bytes[i]);
      end
   endtask

   task automatic write_marker(input logic [7:0] value);
      drain();
      while (!hunting) begin
         send_byte(8'($urandom_range(255, 0)));
         drain();
      end
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      cur_marker = value;
   endtask

   initial begin
      int stall_left;
      rsp_chan.ready <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (rsp_stall_pct > 0 && $urandom_range(99, 0) < rsp_stall_pct) begin
            stall_left = $urandom_range(14, 1) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [7:0] marker_list[0:4];
      int         phase_bytes;
      int         len;
      int         pick;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= 8'h00;
      csr_chan.valid   <= 1'b0;
      csr_chan.data    <= 8'h00;
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      bytes_sent    = 0;
      cur_marker    = lfp_pkg::MARKER_DEFAULT;
      marker_list[0] = lfp_pkg::MARKER_DEFAULT;
      marker_list[1] = 8'h00;
      marker_list[2] = 8'hFF;
      marker_list[3] = 8'($urandom_range(254, 1));
      marker_list[4] = 8'h55;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_marker(lfp_pkg::MARKER_DEFAULT);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(0, 1'b0, -1);
      send_frame(1, 1'b1, -1);
      send_frame(2, 1'b0, -1);
      drain();

      for (int p = 0; p < 5; p++) begin
         write_marker(marker_list[p]);
         if (p == 2 || p == 4) begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end else begin
            req_gap_pct   = $urandom_range(40, 10);
            rsp_stall_pct = $urandom_range(40, 10);
         end
         if (p == 1) begin
            send_frame(255, 1'b0, -1);
         end
         phase_bytes = bytes_sent;
         while (bytes_sent - phase_bytes < 160) begin
            pick = $urandom_range(99, 0);
            if (pick < 70) begin
               len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 0);
               send_frame(len, $urandom_range(4, 0) == 0, -1);
            end else if (pick < 85) begin
               repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255, 0)));
            end else if (pick < 92) begin
               len = $urandom_range(6, 0);
               send_frame(len, 1'b0, $urandom_range(len + 7, 1));
            end else if (pick < 96) begin
               if (p != 4) begin
                  drain();
               end
            end else begin
               send_frame($urandom_range(3, 0), $urandom_range(1, 0) == 1, -1);
            end
         end
      end

      req_chan.valid <= 1'b0;
      wait (pending == 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### files.f
rtl/lfp_pkg.sv
rtl/lfp_if.sv
rtl/lfp_parser.sv
rtl/lfp_rsp_reg.sv
rtl/link_frame_parser_crc16.sv
rtl/lfp_checker.sv
dv/lfp_parse_checker.sv
dv/tb_top.sv
